@@ sv/i2cm_pkg.sv @@
// Package with shared types and constants for the I2C master byte engine.
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 16;
  localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd100;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic              cmd_valid;
    op_t               opcode;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;
  } item_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_seen;
  } result_t;

endpackage

@@ sv/i2cm_fifo.sv @@
// Small item queue used between the front, the engine and the result port.
`timescale 1ns / 1ps
module i2cm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ sv/i2cm_engine.sv @@
// Bus sequencer: advances the START/STOP/WRITE/READ state machine one item per step.
`timescale 1ns / 1ps
module i2cm_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  item_t            item,
  input  logic [CFG_W-1:0] half_period,
  output result_t          result
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_1    = 4'd1,
    PH_2    = 4'd2,
    PH_3    = 4'd3,
    PH_4    = 4'd4,
    PH_5    = 4'd5
  } phase_t;

  op_t                   op_r, op_nxt;
  phase_t                phase_r, phase_nxt;
  logic [3:0]            bit_cnt_r, bit_cnt_nxt;
  logic [BYTE_W-1:0]     shift_r, shift_nxt;
  logic [DELAY_BITS-1:0] dly_r, dly_nxt;
  logic                  scl_r, scl_nxt;
  logic                  sda_r, sda_nxt;
  logic                  ack_r, ack_nxt;
  logic                  ack_choice_r, ack_choice_nxt;
  logic [BYTE_W-1:0]     rx_r, rx_nxt;
  logic                  done_nxt;
  logic [DELAY_BITS-1:0] dly_masked, dly_load;

  assign dly_masked = DELAY_BITS'(half_period);
  assign dly_load   = (dly_masked == '0) ? DELAY_BITS'(1) : dly_masked;

  always_comb begin
    op_nxt         = op_r;
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    dly_nxt        = dly_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_nxt        = ack_r;
    ack_choice_nxt = ack_choice_r;
    rx_nxt         = rx_r;
    done_nxt       = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (item.cmd_valid) begin
        op_nxt      = item.opcode;
        bit_cnt_nxt = '0;
        phase_nxt   = PH_1;
        dly_nxt     = dly_load;
        unique case (item.opcode)
          OP_START: sda_nxt = 1'b1;
          OP_STOP:  sda_nxt = 1'b0;
          OP_WRITE: begin
            shift_nxt = item.tx_byte;
            sda_nxt   = item.tx_byte[BYTE_W-1];
          end
          OP_READ: begin
            ack_choice_nxt = item.send_ack;
            sda_nxt        = 1'b1;
          end
          default: sda_nxt = sda_r;
        endcase
      end
    end else if (dly_r > DELAY_BITS'(1)) begin
      dly_nxt = dly_r - DELAY_BITS'(1);
    end else begin
      dly_nxt = dly_load;
      unique case (op_r)
        OP_START: begin
          priority case (phase_r)
            PH_1: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_2;
            end
            PH_2: begin
              if (!item.sda_in) begin
                scl_nxt   = 1'b0;
                phase_nxt = PH_3;
              end else begin
                sda_nxt   = 1'b0;
                phase_nxt = PH_4;
              end
            end
            PH_3: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_2;
            end
            PH_4: begin
              scl_nxt   = 1'b0;
              phase_nxt = PH_5;
            end
            default: begin
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
          endcase
        end
        OP_STOP: begin
          priority case (phase_r)
            PH_1: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_2;
            end
            PH_2: begin
              sda_nxt   = 1'b1;
              phase_nxt = PH_3;
            end
            default: begin
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
          endcase
        end
        OP_WRITE: begin
          priority case (phase_r)
            PH_1: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_2;
            end
            PH_2: begin
              scl_nxt     = 1'b0;
              shift_nxt   = {shift_r[BYTE_W-2:0], 1'b0};
              bit_cnt_nxt = bit_cnt_r + 4'd1;
              if (bit_cnt_nxt < 4'(BYTE_W)) begin
                sda_nxt   = shift_nxt[BYTE_W-1];
                phase_nxt = PH_1;
              end else begin
                phase_nxt = PH_3;
              end
            end
            PH_3: begin
              sda_nxt   = 1'b1;
              scl_nxt   = 1'b1;
              phase_nxt = PH_4;
            end
            default: begin
              ack_nxt   = !item.sda_in;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
          endcase
        end
        default: begin
          priority case (phase_r)
            PH_1: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_2;
            end
            PH_2: begin
              shift_nxt   = {shift_r[BYTE_W-2:0], item.sda_in};
              scl_nxt     = 1'b0;
              bit_cnt_nxt = bit_cnt_r + 4'd1;
              if (bit_cnt_nxt < 4'(BYTE_W)) begin
                phase_nxt = PH_1;
              end else begin
                if (ack_choice_r) begin
                  sda_nxt = 1'b0;
                end
                phase_nxt = PH_3;
              end
            end
            PH_3: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_4;
            end
            default: begin
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
              rx_nxt    = shift_r;
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end
          endcase
        end
      endcase
    end
  end

  assign result.scl_level = scl_nxt;
  assign result.sda_level = sda_nxt;
  assign result.busy_res  = (phase_nxt != PH_IDLE);
  assign result.done_res  = done_nxt;
  assign result.rx_byte   = rx_nxt;
  assign result.ack_seen  = ack_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r         <= OP_START;
      phase_r      <= PH_IDLE;
      bit_cnt_r    <= '0;
      shift_r      <= '0;
      dly_r        <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_r        <= 1'b0;
      ack_choice_r <= 1'b0;
      rx_r         <= '0;
    end else if (step) begin
      op_r         <= op_nxt;
      phase_r      <= phase_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      dly_r        <= dly_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ack_r        <= ack_nxt;
      ack_choice_r <= ack_choice_nxt;
      rx_r         <= rx_nxt;
    end
  end

endmodule

@@ sv/i2c_master_byte_engine.sv @@
// I2C master byte engine top level: item queue, bus sequencer and result queue.
// Path: a pushed item is registered in the item queue, and its result in the result queue, before it can be popped.
// Throughput: one item per cycle while the result queue has room; the sequencer steps once per item.
// Each item yields exactly one result item.
// Reset (rst_n low, synchronous) empties both queues, idles the sequencer with
// SCL/SDA released, and sets the half-period register to 100.
`timescale 1ns / 1ps
module i2c_master_byte_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_cmd_valid,
  input  logic [1:0]        in_opcode,
  input  logic [BYTE_W-1:0] in_tx_byte,
  input  logic              in_send_ack,
  input  logic              in_sda_in,
  output logic              empty,
  input  logic              pop,
  output logic              out_scl_level,
  output logic              out_sda_level,
  output logic              out_busy_res,
  output logic              out_done_res,
  output logic [BYTE_W-1:0] out_rx_byte,
  output logic              out_ack_seen,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] half_period_r;
  item_t            in_item, q_item;
  result_t          eng_res, out_res;
  logic             q_empty, res_full, step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      half_period_r <= cfg_data;
    end
  end

  // front: pack and type the incoming item
  always_comb begin
    in_item.cmd_valid = in_cmd_valid;
    in_item.opcode    = op_t'(in_opcode);
    in_item.tx_byte   = in_tx_byte;
    in_item.send_ack  = in_send_ack;
    in_item.sda_in    = in_sda_in;
  end

  i2cm_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(2)
  ) u_in_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(in_item),
    .full   (full),
    .rd_en  (step),
    .rd_data(q_item),
    .empty  (q_empty)
  );

  assign step = !q_empty && !res_full;

  i2cm_engine #(
    .DELAY_BITS(DELAY_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (q_item),
    .half_period(half_period_r),
    .result     (eng_res)
  );

  i2cm_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (step),
    .wr_data(eng_res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(out_res),
    .empty  (empty)
  );

  assign out_scl_level = out_res.scl_level;
  assign out_sda_level = out_res.sda_level;
  assign out_busy_res  = out_res.busy_res;
  assign out_done_res  = out_res.done_res;
  assign out_rx_byte   = out_res.rx_byte;
  assign out_ack_seen  = out_res.ack_seen;

endmodule

@@ tb/i2c_bus_checker.sv @@
// Checker for the I2C master byte engine: predicts every bus-state item and compares it.
`timescale 1ns / 1ps
module i2c_bus_checker
  import i2cm_pkg::*;
#(
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              full,
  input  logic              in_cmd_valid,
  input  logic [1:0]        in_opcode,
  input  logic [BYTE_W-1:0] in_tx_byte,
  input  logic              in_send_ack,
  input  logic              in_sda_in,
  input  logic              empty,
  input  logic              pop,
  input  logic              out_scl_level,
  input  logic              out_sda_level,
  input  logic              out_busy_res,
  input  logic              out_done_res,
  input  logic [BYTE_W-1:0] out_rx_byte,
  input  logic              out_ack_seen,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending
);

  localparam logic [31:0] DELAY_MASK =
    (DELAY_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << DELAY_BITS) - 32'd1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_HIGH,
    ST_TAIL,
    ST_ACK,
    ST_END
  } step_t;

  logic [CFG_W-1:0]  half_period;
  op_t               cur_op;
  step_t             step;
  logic [3:0]        bit_cnt;
  logic [BYTE_W-1:0] shifter;
  logic [31:0]       wait_cnt;
  logic              scl_q;
  logic              sda_q;
  logic              ack_q;
  logic              ack_pick;
  logic [BYTE_W-1:0] rx_q;
  result_t           line_q[$];

  function automatic logic [31:0] delay_load();
    logic [31:0] d;
    d = 32'(half_period) & DELAY_MASK;
    return (d == 32'd0) ? 32'd1 : d;
  endfunction

  // One engine cycle; returns the line state after this cycle's update.
  function automatic result_t engine_cycle(input item_t it);
    result_t r;
    logic    fin;
    fin = 1'b0;
    if (step == ST_IDLE) begin
      if (it.cmd_valid) begin
        cur_op  = it.opcode;
        bit_cnt = 4'd0;
        step    = ST_SETUP;
        case (it.opcode)
          OP_START: sda_q = 1'b1;
          OP_STOP:  sda_q = 1'b0;
          OP_WRITE: begin
            shifter = it.tx_byte;
            sda_q   = it.tx_byte[7];
          end
          default: begin
            ack_pick = it.send_ack;
            sda_q    = 1'b1;
          end
        endcase
        wait_cnt = delay_load();
      end
    end else if (wait_cnt > 32'd1) begin
      wait_cnt = wait_cnt - 32'd1;
    end else begin
      case (cur_op)
        OP_START: begin
          case (step)
            ST_SETUP: begin
              scl_q = 1'b1;
              step  = ST_HIGH;
              wait_cnt = delay_load();
            end
            ST_HIGH: begin
              // stuck bus: keep clocking while SDA reads low
              if (!it.sda_in) begin
                scl_q = 1'b0;
                step  = ST_TAIL;
              end else begin
                sda_q = 1'b0;
                step  = ST_ACK;
              end
              wait_cnt = delay_load();
            end
            ST_TAIL: begin
              scl_q = 1'b1;
              step  = ST_HIGH;
              wait_cnt = delay_load();
            end
            ST_ACK: begin
              scl_q = 1'b0;
              step  = ST_END;
              wait_cnt = delay_load();
            end
            default: fin = 1'b1;
          endcase
        end
        OP_STOP: begin
          case (step)
            ST_SETUP: begin
              scl_q = 1'b1;
              step  = ST_HIGH;
              wait_cnt = delay_load();
            end
            ST_HIGH: begin
              sda_q = 1'b1;
              step  = ST_TAIL;
              wait_cnt = delay_load();
            end
            default: fin = 1'b1;
          endcase
        end
        OP_WRITE: begin
          case (step)
            ST_SETUP: begin
              scl_q = 1'b1;
              step  = ST_HIGH;
              wait_cnt = delay_load();
            end
            ST_HIGH: begin
              scl_q   = 1'b0;
              shifter = {shifter[BYTE_W-2:0], 1'b0};
              bit_cnt = bit_cnt + 4'd1;
              if (bit_cnt < 4'd8) begin
                sda_q = shifter[BYTE_W-1];
                step  = ST_SETUP;
              end else begin
                step = ST_TAIL;
              end
              wait_cnt = delay_load();
            end
            ST_TAIL: begin
              sda_q = 1'b1;
              scl_q = 1'b1;
              step  = ST_ACK;
              wait_cnt = delay_load();
            end
            default: begin
              ack_q = !it.sda_in;
              scl_q = 1'b0;
              sda_q = 1'b0;
              fin   = 1'b1;
            end
          endcase
        end
        default: begin
          case (step)
            ST_SETUP: begin
              scl_q = 1'b1;
              step  = ST_HIGH;
              wait_cnt = delay_load();
            end
            ST_HIGH: begin
              shifter = {shifter[BYTE_W-2:0], it.sda_in};
              scl_q   = 1'b0;
              bit_cnt = bit_cnt + 4'd1;
              if (bit_cnt < 4'd8) begin
                step = ST_SETUP;
              end else begin
                if (ack_pick) sda_q = 1'b0;
                step = ST_TAIL;
              end
              wait_cnt = delay_load();
            end
            ST_TAIL: begin
              scl_q = 1'b1;
              step  = ST_ACK;
              wait_cnt = delay_load();
            end
            default: begin
              scl_q = 1'b0;
              sda_q = 1'b1;
              rx_q  = shifter;
              fin   = 1'b1;
            end
          endcase
        end
      endcase
    end
    if (fin) step = ST_IDLE;
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res  = (step != ST_IDLE);
    r.done_res  = fin;
    r.rx_byte   = rx_q;
    r.ack_seen  = ack_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v, got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    item_t   it;
    if (!rst_n) begin
      half_period = HALF_PERIOD_RST;
      cur_op      = OP_START;
      step        = ST_IDLE;
      bit_cnt     = '0;
      shifter     = '0;
      wait_cnt    = '0;
      scl_q       = 1'b1;
      sda_q       = 1'b1;
      ack_q       = 1'b0;
      ack_pick    = 1'b0;
      rx_q        = '0;
      line_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) half_period = cfg_data;
      if (pop && !empty) begin
        if (line_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          want = line_q.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(out_scl_level));
          check_field("sda_level", 8'(want.sda_level), 8'(out_sda_level));
          check_field("busy_res", 8'(want.busy_res), 8'(out_busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_done_res));
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("ack_seen", 8'(want.ack_seen), 8'(out_ack_seen));
        end
      end
      if (push && !full) begin
        it.cmd_valid = in_cmd_valid;
        it.opcode    = op_t'(in_opcode);
        it.tx_byte   = in_tx_byte;
        it.send_ack  = in_send_ack;
        it.sda_in    = in_sda_in;
        line_q.push_back(engine_cycle(it));
      end
    end
    pending = line_q.size();
  end

endmodule

@@ tb/i2c_master_byte_engine_test.sv @@
// Testbench top for the I2C master byte engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module i2c_master_byte_engine_test;
  import i2cm_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic              in_cmd_valid = 1'b0;
  logic [1:0]        in_opcode = 2'd0;
  logic [BYTE_W-1:0] in_tx_byte = '0;
  logic              in_send_ack = 1'b0;
  logic              in_sda_in = 1'b1;
  logic              empty;
  logic              pop = 1'b0;
  logic              out_scl_level;
  logic              out_sda_level;
  logic              out_busy_res;
  logic              out_done_res;
  logic [BYTE_W-1:0] out_rx_byte;
  logic              out_ack_seen;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;
  int                fail_count;
  int                pending;

  int                cur_d = 100;
  int                burst_left = 0;
  bit                gaps_on = 1'b1;
  int                sent = 0;
  logic [15:0]       stall_pat = 16'hFFFF;
  logic [5:0]        rx_tick = '0;
  logic [CFG_W-1:0]  cfg_plan [5] = '{16'd1, 16'd2, 16'd4, 16'd3, 16'd1};

  i2c_master_byte_engine i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_cmd_valid  (in_cmd_valid),
    .in_opcode     (in_opcode),
    .in_tx_byte    (in_tx_byte),
    .in_send_ack   (in_send_ack),
    .in_sda_in     (in_sda_in),
    .empty         (empty),
    .pop           (pop),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_rx_byte   (out_rx_byte),
    .out_ack_seen  (out_ack_seen),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  i2c_bus_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_cmd_valid  (in_cmd_valid),
    .in_opcode     (in_opcode),
    .in_tx_byte    (in_tx_byte),
    .in_send_ack   (in_send_ack),
    .in_sda_in     (in_sda_in),
    .empty         (empty),
    .pop           (pop),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_rx_byte   (out_rx_byte),
    .out_ack_seen  (out_ack_seen),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: pops on a rotating stall pattern, sometimes at full rate
  always @(negedge clk) begin
    rx_tick <= rx_tick + 6'd1;
    pop     <= rst_n & stall_pat[rx_tick[3:0]];
    if (rx_tick == 6'd63) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h5555);
    end
  end

  function automatic int cmd_cycles(input op_t op, input int d);
    case (op)
      OP_START: return 4 * d;
      OP_STOP:  return 3 * d;
      default:  return 18 * d;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic put_item(input item_t it);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    push         <= 1'b1;
    in_cmd_valid <= it.cmd_valid;
    in_opcode    <= it.opcode;
    in_tx_byte   <= it.tx_byte;
    in_send_ack  <= it.send_ack;
    in_sda_in    <= it.sda_in;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // bit k-1 of sda_bits is the SDA level on idle item k
  task automatic idle_items(input int n, input logic [31:0] sda_bits, input int busy_n,
                            input int noise);
    item_t it;
    for (int k = 1; k <= n; k++) begin
      it.cmd_valid = (noise != 0) && (k < busy_n) && ($urandom_range(1, noise) == 1);
      it.opcode    = op_t'($urandom_range(0, 3));
      it.tx_byte   = 8'($urandom);
      it.send_ack  = 1'($urandom_range(0, 1));
      it.sda_in    = (k <= 32) ? sda_bits[k-1] : 1'($urandom_range(0, 1));
      put_item(it);
    end
  endtask

  task automatic run_cmd(input op_t op, input logic [7:0] b, input logic ack, input int slack,
                         input logic [31:0] sda_bits, input int noise);
    item_t it;
    int    len;
    it.cmd_valid = 1'b1;
    it.opcode    = op;
    it.tx_byte   = b;
    it.send_ack  = ack;
    it.sda_in    = 1'($urandom_range(0, 1));
    put_item(it);
    len = cmd_cycles(op, cur_d);
    idle_items(len + slack, sda_bits, len, noise);
  endtask

  task automatic set_half_period(input logic [CFG_W-1:0] v);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_d = (v == '0) ? 1 : int'(v);
  endtask

  task automatic run_transfer();
    logic [7:0] addr;
    int         n;
    addr = 8'($urandom);
    n    = $urandom_range(1, 3);
    run_cmd(OP_START, 8'($urandom), 1'($urandom_range(0, 1)), 4 * cur_d + $urandom_range(0, 2),
            $urandom | $urandom, 0);
    run_cmd(OP_WRITE, addr, 1'($urandom_range(0, 1)), $urandom_range(0, 2), $urandom, 16);
    repeat (n) begin
      run_cmd(addr[0] ? OP_READ : OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)),
              $urandom_range(0, 2), $urandom, 16);
    end
    run_cmd(OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 2),
            $urandom, 16);
  endtask

  initial begin : stim
    int phase_start;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset half period
    run_cmd(OP_STOP, 8'h00, 1'b0, 1, '1, 0);

    // zero half period behaves like a setting of 1
    set_half_period(16'h0000);
    run_cmd(OP_START, 8'h00, 1'b0, 0, '1, 0);
    run_cmd(OP_WRITE, 8'hFF, 1'b0, 0, 32'h0, 0);
    run_cmd(OP_WRITE, 8'h00, 1'b1, 0, '1, 0);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, 0, $urandom, 1);
    run_cmd(OP_READ, 8'h00, 1'b1, 0, '1, 0);
    run_cmd(OP_READ, 8'hFF, 1'b0, 0, 32'h0, 0);
    // repeated start with SDA stuck low, so the sequencer clocks SCL until SDA is released
    run_cmd(OP_START, 8'h00, 1'b0, 4, ~32'h0000_000A, 0);
    run_cmd(OP_READ, 8'h00, 1'b1, -1, $urandom, 0);
    // lands in the finishing cycle, dropped
    run_cmd(OP_STOP, 8'h00, 1'b0, 0, '1, 0);
    run_cmd(OP_STOP, 8'h00, 1'b0, 0, '1, 0);

    // half period changed while a write is in flight
    set_half_period(16'd3);
    run_cmd(OP_WRITE, 8'h3C, 1'b0, 5 - cmd_cycles(OP_WRITE, 3), $urandom, 0);
    set_half_period(16'd2);
    idle_items(40, $urandom, 0, 0);

    foreach (cfg_plan[i]) begin
      set_half_period(cfg_plan[i]);
      phase_start = sent;
      while (sent - phase_start < 200) begin
        if ($urandom_range(0, 3) != 0) begin
          run_transfer();
        end else begin
          run_cmd(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)),
                  int'($urandom_range(0, 5)) - 2, $urandom, 4);
        end
      end
    end

    // widest half period: start a stop and check its start without waiting for it to finish
    set_half_period(16'hFFFF);
    gaps_on = 1'b0;
    run_cmd(OP_STOP, 8'($urandom), 1'b0, 2 - cmd_cycles(OP_STOP, cur_d), $urandom, 0);

    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
